// ----- rtl/msd_pkg.sv -----
`default_nettype none
package msd_pkg;

	localparam int DIGIT_COUNT_DEF    = 4;
	localparam int MAX_BRIGHTNESS_DEF = 4;

	typedef logic [5:0] glyph_t;
	typedef logic [7:0] seg_t;

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_SET_CHAR   = 3'd1,
		OP_SET_NUMBER = 3'd2,
		OP_CLEAR      = 3'd3,
		OP_CLEAR_ALL  = 3'd4,
		OP_BRIGHTNESS = 3'd5
	} op_t;

	localparam glyph_t GLYPH_LETTER_A = 6'd10;
	localparam glyph_t GLYPH_DASH     = 6'd36;
	localparam glyph_t GLYPH_POINT    = 6'd37;
	localparam glyph_t GLYPH_BLANK    = 6'd38;

	localparam logic [7:0] NUMBER_LIMIT = 8'd10;

	function automatic glyph_t char_to_glyph(input logic [7:0] c);
		glyph_t g;
		g = GLYPH_BLANK;
		if (c >= "0" && c <= "9") begin
			g = 6'(c - 8'("0"));
		end else if (c >= "A" && c <= "Z") begin
			g = 6'(c - 8'("A")) + GLYPH_LETTER_A;
		end else if (c >= "a" && c <= "z") begin
			g = 6'(c - 8'("a")) + GLYPH_LETTER_A;
		end else if (c == "-") begin
			g = GLYPH_DASH;
		end else if (c == ".") begin
			g = GLYPH_POINT;
		end
		return g;
	endfunction

	function automatic seg_t glyph_segments(input glyph_t code);
		seg_t s;
		case (code)
			6'd0:  s = 8'h3F;
			6'd1:  s = 8'h06;
			6'd2:  s = 8'h5B;
			6'd3:  s = 8'h4F;
			6'd4:  s = 8'h66;
			6'd5:  s = 8'h6D;
			6'd6:  s = 8'h7D;
			6'd7:  s = 8'h07;
			6'd8:  s = 8'h7F;
			6'd9:  s = 8'h6F;
			6'd10: s = 8'h77;
			6'd11: s = 8'h7C;
			6'd12: s = 8'h39;
			6'd13: s = 8'h5E;
			6'd14: s = 8'h79;
			6'd15: s = 8'h71;
			6'd16: s = 8'h7D;
			6'd17: s = 8'h76;
			6'd18: s = 8'h30;
			6'd19: s = 8'h0E;
			6'd21: s = 8'h38;
			6'd23: s = 8'h54;
			6'd24: s = 8'h5C;
			6'd25: s = 8'h73;
			6'd26: s = 8'h67;
			6'd27: s = 8'h50;
			6'd28: s = 8'h6D;
			6'd29: s = 8'h78;
			6'd30: s = 8'h3E;
			6'd34: s = 8'h6E;
			6'd35: s = 8'h5B;
			6'd36: s = 8'h40;
			6'd37: s = 8'h80;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/msd_intf.sv -----
`default_nettype none
interface msd_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        op;
	logic [7:0]        digit_index;
	logic [7:0]        ascii_char;
	logic [7:0]        number_value;
	logic signed [7:0] brightness_delta;

	modport source (output valid, op, digit_index, ascii_char, number_value,
		brightness_delta, input ready);
	modport sink (input valid, op, digit_index, ascii_char, number_value,
		brightness_delta, output ready);
endinterface

interface msd_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] segment_lines;
	logic [1:0] digit_select;
	logic [2:0] brightness_level;

	modport source (output valid, segment_lines, digit_select, brightness_level,
		input ready);
	modport sink (input valid, segment_lines, digit_select, brightness_level,
		output ready);
endinterface

interface msd_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/mux_seven_segment_driver.sv -----
// A result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle; a request is taken whenever the result
// register is empty or its result is taken in the same cycle.
// Reset: all digits blank, brightness at maximum, scan and PWM phase at zero,
// held segments and select at zero, minimum brightness zero, no result pending.
`default_nettype none
module mux_seven_segment_driver #(
	parameter int DIGIT_COUNT    = msd_pkg::DIGIT_COUNT_DEF,
	parameter int MAX_BRIGHTNESS = msd_pkg::MAX_BRIGHTNESS_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	msd_req_if.sink       req,
	msd_rsp_if.source     rsp,
	msd_cfg_if.sink       cfg
);
	import msd_pkg::*;

	localparam int DW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int PW = (MAX_BRIGHTNESS > 1) ? $clog2(MAX_BRIGHTNESS) : 1;
	localparam int BW = $clog2(MAX_BRIGHTNESS + 1);

	glyph_t          glyph_q [DIGIT_COUNT];
	logic [BW-1:0]   bri_q;
	logic [DW-1:0]   scan_q;
	logic [PW-1:0]   pwm_q;
	seg_t            held_seg_q;
	logic [1:0]      held_sel_q;
	logic [2:0]      min_bri_q;
	logic            out_valid_q;

	logic            accept;
	op_t             op;
	logic            idx_ok;
	logic [DW-1:0]   idx;
	logic [PW:0]     pwm_inc;
	logic [PW-1:0]   phase;
	logic [DW-1:0]   scan_next;
	seg_t            tick_seg;
	logic signed [9:0] bri_sum;
	logic signed [9:0] bri_clamp;

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign op        = op_t'(req.op);
	assign idx_ok    = req.digit_index < 8'(DIGIT_COUNT);
	assign idx       = req.digit_index[DW-1:0];

	assign cfg.ready = 1'b1;

	assign rsp.valid            = out_valid_q;
	assign rsp.segment_lines    = held_seg_q;
	assign rsp.digit_select     = held_sel_q;
	assign rsp.brightness_level = 3'(bri_q);

	always_comb begin
		pwm_inc   = {1'b0, pwm_q} + (PW+1)'(1);
		phase     = (pwm_inc == (PW+1)'(MAX_BRIGHTNESS)) ? '0 : pwm_inc[PW-1:0];
		scan_next = (scan_q == DW'(DIGIT_COUNT - 1)) ? '0 : scan_q + DW'(1);
		tick_seg  = (BW'(phase) >= bri_q) ? '0 : glyph_segments(glyph_q[scan_q]);
		bri_sum   = $signed({{(10-BW){1'b0}}, bri_q})
			+ $signed({{2{req.brightness_delta[7]}}, req.brightness_delta});
		bri_clamp = bri_sum;
		if (bri_clamp < $signed({7'b0, min_bri_q})) begin
			bri_clamp = $signed({7'b0, min_bri_q});
		end
		if (bri_clamp > 10'(MAX_BRIGHTNESS)) begin
			bri_clamp = 10'(MAX_BRIGHTNESS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bri_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			min_bri_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				glyph_q[i] <= GLYPH_BLANK;
			end
			bri_q      <= BW'(MAX_BRIGHTNESS);
			scan_q     <= '0;
			pwm_q      <= '0;
			held_seg_q <= '0;
			held_sel_q <= '0;
		end else if (accept) begin
			unique case (op)
				OP_TICK: begin
					held_seg_q <= tick_seg;
					held_sel_q <= 2'(scan_q);
					pwm_q      <= phase;
					if (phase == '0) begin
						scan_q <= scan_next;
					end
				end
				OP_SET_CHAR: begin
					if (idx_ok) begin
						glyph_q[idx] <= char_to_glyph(req.ascii_char);
					end
				end
				OP_SET_NUMBER: begin
					if (idx_ok && req.number_value < NUMBER_LIMIT) begin
						glyph_q[idx] <= 6'(req.number_value);
					end
				end
				OP_CLEAR: begin
					if (idx_ok) begin
						glyph_q[idx] <= GLYPH_BLANK;
					end
				end
				OP_CLEAR_ALL: begin
					for (int i = 0; i < DIGIT_COUNT; i++) begin
						glyph_q[i] <= GLYPH_BLANK;
					end
				end
				OP_BRIGHTNESS: begin
					bri_q <= bri_clamp[BW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	a_pwm_range: assert property (@(posedge clk) disable iff (!arst_n)
		pwm_q < PW'(MAX_BRIGHTNESS - 1) || pwm_q == PW'(MAX_BRIGHTNESS - 1))
		else $error("pwm phase out of range");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q < DW'(DIGIT_COUNT - 1) || scan_q == DW'(DIGIT_COUNT - 1))
		else $error("scan digit out of range");

	a_bri_range: assert property (@(posedge clk) disable iff (!arst_n)
		bri_q <= BW'(MAX_BRIGHTNESS))
		else $error("brightness above maximum");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.valid)
		else $error("accepted request produced no result");

	a_tick_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_TICK && phase != '0 |=> $stable(scan_q))
		else $error("scan advanced mid phase cycle");

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import msd_pkg::*;

	localparam int DIGITS      = DIGIT_COUNT_DEF;
	localparam int LEVELS      = MAX_BRIGHTNESS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int GLYPH_COUNT = 39;

	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef struct packed {
		seg_t       segments;
		logic [1:0] select;
		logic [2:0] level;
	} frame_t;

	logic clk;
	logic arst_n;

	msd_req_if req_if ();
	msd_rsp_if rsp_if ();
	msd_cfg_if cfg_if ();

	mux_seven_segment_driver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	seg_t       shape_rom [GLYPH_COUNT];
	glyph_t     shown [DIGITS];
	int         level;
	int         scan_pos;
	int         pwm_pos;
	seg_t       held_seg;
	logic [1:0] held_sel;
	int         floor_level;
	frame_t     pending_frames [$];
	int         send_idle;
	int         recv_idle;
	int         mismatches;
	int         cycle_count;

	string glyph_chars =
		"0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-.";

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic glyph_t glyph_of_char(input logic [7:0] c);
		if (c >= "0" && c <= "9") return glyph_t'(c - "0");
		if (c >= "A" && c <= "Z") return glyph_t'(c - "A") + GLYPH_LETTER_A;
		if (c >= "a" && c <= "z") return glyph_t'(c - "a") + GLYPH_LETTER_A;
		if (c == "-") return GLYPH_DASH;
		if (c == ".") return GLYPH_POINT;
		return GLYPH_BLANK;
	endfunction

	task automatic reset_display_state();
		foreach (shown[i]) shown[i] = GLYPH_BLANK;
		level       = LEVELS;
		scan_pos    = 0;
		pwm_pos     = 0;
		held_seg    = '0;
		held_sel    = '0;
		floor_level = 0;
	endtask

	task automatic predict_frame(input logic [2:0] op, input logic [7:0] idx,
		input logic [7:0] ch, input logic [7:0] num, input logic signed [7:0] delta);
		int     sum;
		int     next_pwm;
		seg_t   segs;
		frame_t f;
		case (op)
			OP_TICK: begin
				next_pwm = (pwm_pos + 1) % LEVELS;
				segs = shape_rom[shown[scan_pos]];
				if (next_pwm >= level) segs = '0;
				held_seg = segs;
				held_sel = 2'(scan_pos);
				if (next_pwm == 0) scan_pos = (scan_pos + 1) % DIGITS;
				pwm_pos = next_pwm;
			end
			OP_SET_CHAR: begin
				if (idx < DIGITS) shown[idx] = glyph_of_char(ch);
			end
			OP_SET_NUMBER: begin
				if (idx < DIGITS && num < NUMBER_LIMIT) shown[idx] = glyph_t'(num);
			end
			OP_CLEAR: begin
				if (idx < DIGITS) shown[idx] = GLYPH_BLANK;
			end
			OP_CLEAR_ALL: begin
				foreach (shown[i]) shown[i] = GLYPH_BLANK;
			end
			OP_BRIGHTNESS: begin
				sum = level + int'(delta);
				if (sum < floor_level) sum = floor_level;
				if (sum > LEVELS) sum = LEVELS;
				level = sum;
			end
			default: begin
			end
		endcase
		f.segments = held_seg;
		f.select   = held_sel;
		f.level    = 3'(level);
		pending_frames.push_back(f);
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin : check_frames
		frame_t want;
		if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_frames.size() == 0) begin
				report_mismatch("unexpected result", rsp_if.segment_lines, 0);
			end else begin
				want = pending_frames.pop_front();
				if (rsp_if.segment_lines !== want.segments)
					report_mismatch("segment_lines", rsp_if.segment_lines, want.segments);
				if (rsp_if.digit_select !== want.select)
					report_mismatch("digit_select", rsp_if.digit_select, want.select);
				if (rsp_if.brightness_level !== want.level)
					report_mismatch("brightness_level", rsp_if.brightness_level, want.level);
			end
		end
		rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	task automatic send_request(input logic [2:0] op, input logic [7:0] idx,
		input logic [7:0] ch, input logic [7:0] num, input logic signed [7:0] delta);
		while ($urandom_range(0, 99) < send_idle) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid            <= 1'b1;
		req_if.op               <= op;
		req_if.digit_index      <= idx;
		req_if.ascii_char       <= ch;
		req_if.number_value     <= num;
		req_if.brightness_delta <= delta;
		@(posedge clk);
		while (req_if.ready !== 1'b1) @(posedge clk);
		predict_frame(op, idx, ch, num, delta);
	endtask

	task automatic tick();
		send_request(OP_TICK, '0, '0, '0, '0);
	endtask

	task automatic drain_frames();
		req_if.valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_floor(input logic [2:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= value;
		@(posedge clk);
		while (cfg_if.ready !== 1'b1) @(posedge clk);
		cfg_if.valid <= 1'b0;
		floor_level = value;
	endtask

	task automatic random_request();
		int                pick;
		logic [2:0]        op;
		logic [7:0]        idx;
		logic [7:0]        ch;
		logic [7:0]        num;
		logic signed [7:0] delta;
		pick = $urandom_range(0, 99);
		if (pick < 40) op = OP_TICK;
		else if (pick < 58) op = OP_SET_CHAR;
		else if (pick < 70) op = OP_SET_NUMBER;
		else if (pick < 78) op = OP_CLEAR;
		else if (pick < 81) op = OP_CLEAR_ALL;
		else if (pick < 94) op = OP_BRIGHTNESS;
		else op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
		idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, DIGITS - 1));
		ch = ($urandom_range(0, 3) == 0) ? 8'($urandom)
			: glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
		num = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
		delta = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6) - 3);
		send_request(op, idx, ch, num, delta);
	endtask

	task automatic test_directed_writes();
		write_floor(3'd0);
		send_request(OP_SET_CHAR, 8'd0, "8", '0, '0);
		send_request(OP_SET_CHAR, 8'd1, "z", '0, '0);
		send_request(OP_SET_CHAR, 8'd2, "-", '0, '0);
		send_request(OP_SET_CHAR, 8'd3, ".", '0, '0);
		repeat (4) tick();
		send_request(OP_SET_CHAR, 8'd255, "A", '0, '0);
		send_request(OP_SET_CHAR, 8'd3, 8'hFF, '0, '0);
		send_request(OP_SET_CHAR, 8'd2, "K", '0, '0);
		send_request(OP_SET_NUMBER, 8'd0, 8'h00, 8'd9, '0);
		send_request(OP_SET_NUMBER, 8'd1, '0, NUMBER_LIMIT, '0);
		send_request(OP_SET_NUMBER, 8'd2, '0, 8'd255, '0);
		send_request(OP_SET_NUMBER, 8'd3, '0, 8'd0, '0);
		send_request(OP_CLEAR, 8'd1, '0, '0, '0);
		send_request(OP_CLEAR, 8'd4, '0, '0, '0);
		send_request(OP_BRIGHTNESS, '0, '0, '0, -8'sd128);
		send_request(OP_BRIGHTNESS, '0, '0, '0, 8'sd127);
		send_request(OP_BRIGHTNESS, '0, '0, '0, -8'sd2);
		send_request(OP_SPARE_6, 8'hFF, 8'hFF, 8'hFF, -8'sd1);
		send_request(OP_SPARE_7, '0, '0, '0, '0);
		repeat (4) tick();
		send_request(OP_CLEAR_ALL, '0, '0, '0, '0);
		tick();
	endtask

	task automatic test_floor_above_max();
		drain_frames();
		write_floor(3'd7);
		send_request(OP_BRIGHTNESS, '0, '0, '0, -8'sd128);
		tick();
		drain_frames();
		write_floor(3'd5);
		send_request(OP_BRIGHTNESS, '0, '0, '0, -8'sd1);
		drain_frames();
		write_floor(3'd2);
		send_request(OP_SET_NUMBER, 8'd0, '0, 8'd5, '0);
		send_request(OP_BRIGHTNESS, '0, '0, '0, -8'sd128);
		repeat (4) tick();
	endtask

	task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
		input logic [2:0] floor_value, input int count);
		drain_frames();
		write_floor(floor_value);
		send_idle = sender_idle;
		recv_idle = receiver_idle;
		repeat (count) random_request();
	endtask

	initial begin
		shape_rom = '{
			8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
			8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h7D, 8'h76, 8'h30, 8'h0E,
			8'h00, 8'h38, 8'h00, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
			8'h3E, 8'h00, 8'h00, 8'h00, 8'h6E, 8'h5B,
			8'h40, 8'h80, 8'h00
		};
		reset_display_state();
		send_idle   = 0;
		recv_idle   = 0;
		arst_n                  <= 1'b0;
		req_if.valid            <= 1'b0;
		req_if.op               <= '0;
		req_if.digit_index      <= '0;
		req_if.ascii_char       <= '0;
		req_if.number_value     <= '0;
		req_if.brightness_delta <= '0;
		cfg_if.valid            <= 1'b0;
		cfg_if.data             <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_writes();
		test_floor_above_max();
		test_random_traffic(16, 46, 3'd1, 520);
		test_random_traffic(46, 16, 3'd4, 520);
		test_random_traffic(0, 0, 3'd0, 520);

		drain_frames();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
